// ===== hw/rtl/pnmb_pkg.sv =====
// ----------------------------------------------------------------------------
// pnmb_pkg
// Shared types, constants and helpers of the periodic neighbour max bound core.
// ----------------------------------------------------------------------------
package pnmb_pkg;

    localparam int          MAX_EDGE_DEF = 16;
    localparam logic [4:0]  EDGE_RESET   = 5'd16;
    localparam logic [3:0]  CUBE_READS   = 4'd8;
    localparam logic [30:0] MAG_LIMIT    = 31'h7FFF_FFFF;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DONE
    } t_state;

    // Memory port strobes from the sequencer.
    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

    // Finished query result handed to the output register.
    typedef struct packed {
        logic        valid;
        logic [30:0] bound;
        logic        range_error;
    } t_result;

    // Absolute value of a Q16.16 sample, saturated at 2^31-1.
    function automatic logic [30:0] mag_abs(input logic [31:0] raw);
        logic [31:0] neg;
        neg = ~raw + 32'd1;
        if (!raw[31]) begin
            return raw[30:0];
        end
        if (neg[31]) begin
            return MAG_LIMIT;
        end
        return neg[30:0];
    endfunction

endpackage

// ===== hw/rtl/pnmb_if.sv =====
// ----------------------------------------------------------------------------
// pnmb_if
// Valid/ready channels of the core: command items in, query results out.
// ----------------------------------------------------------------------------
interface pnmb_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [3:0]  coord_x;
    logic [3:0]  coord_y;
    logic [3:0]  coord_z;
    logic [31:0] sample;

    modport source (output valid, opcode, coord_x, coord_y, coord_z, sample, input ready);
    modport sink   (input valid, opcode, coord_x, coord_y, coord_z, sample, output ready);
endinterface

interface pnmb_out_if;
    logic        valid;
    logic        ready;
    logic [30:0] bound;
    logic        range_error;

    modport source (output valid, bound, range_error, input ready);
    modport sink   (input valid, bound, range_error, output ready);
endinterface

// ===== hw/rtl/pnmb_grid.sv =====
// ----------------------------------------------------------------------------
// pnmb_grid
// Single-port sample store, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module pnmb_grid #(
    parameter int DEPTH = 4096,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  pnmb_pkg::t_mem_ctl   i_ctl,
    input  logic [AW-1:0]        i_addr,
    input  logic [31:0]          i_wdata,
    output logic [31:0]          o_rdata
);
    import pnmb_pkg::*;

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/pnmb_seq.sv =====
// ----------------------------------------------------------------------------
// pnmb_seq
// Command sequencer: stores writes, walks the eight cube reads of a query
// and keeps the running peak magnitude.
// ----------------------------------------------------------------------------
module pnmb_seq #(
    parameter int MAX_EDGE = pnmb_pkg::MAX_EDGE_DEF,
    parameter int DEPTH    = MAX_EDGE * MAX_EDGE * MAX_EDGE,
    parameter int AW       = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    pnmb_in_if.sink              i_in,
    input  logic [4:0]           i_edge_len,
    output pnmb_pkg::t_mem_ctl   o_mem,
    output logic [AW-1:0]        o_mem_addr,
    output logic [31:0]          o_mem_wdata,
    input  logic [31:0]          i_mem_rdata,
    output pnmb_pkg::t_result    o_res,
    input  logic                 i_res_ready
);
    import pnmb_pkg::*;

    localparam logic [4:0] EdgeClip = (MAX_EDGE > 31) ? 5'd31 : 5'(MAX_EDGE);

    t_state      r_state, n_state;
    logic [3:0]  r_cnt, n_cnt;
    logic [30:0] r_best, n_best;
    logic        r_err, n_err;
    logic        r_rd_vld;
    logic [4:0]  r_x0, r_x1, r_y0, r_y1, r_z0, r_z1;

    logic [4:0]  edge_n;
    logic [4:0]  in_x, in_y, in_z;
    logic        in_inside;
    logic        in_acc;
    logic [30:0] mag_now;
    logic [4:0]  sel_x, sel_y, sel_z;

    function automatic logic [4:0] step_wrap(input logic [4:0] k, input logic [4:0] n);
        logic [4:0] k1;
        k1 = k + 5'd1;
        return (k1 >= n) ? 5'd0 : k1;
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [4:0] x, input logic [4:0] y,
                                                 input logic [4:0] z);
        int unsigned a;
        a = (int'(x) * MAX_EDGE + int'(y)) * MAX_EDGE + int'(z);
        return AW'(a);
    endfunction

    assign edge_n    = (i_edge_len > EdgeClip) ? EdgeClip : i_edge_len;
    assign in_x      = {1'b0, i_in.coord_x};
    assign in_y      = {1'b0, i_in.coord_y};
    assign in_z      = {1'b0, i_in.coord_z};
    assign in_inside = (in_x < edge_n) && (in_y < edge_n) && (in_z < edge_n);
    assign in_acc    = i_in.valid && i_in.ready;
    assign mag_now   = mag_abs(i_mem_rdata);

    // cube corner k: bit 2 picks x+1, bit 1 y+1, bit 0 z+1
    assign sel_x = r_cnt[2] ? r_x1 : r_x0;
    assign sel_y = r_cnt[1] ? r_y1 : r_y0;
    assign sel_z = r_cnt[0] ? r_z1 : r_z0;

    always_comb begin
        n_state           = r_state;
        n_cnt             = r_cnt;
        n_best            = r_best;
        n_err             = r_err;
        o_mem             = '0;
        o_mem_addr        = cell_addr(sel_x, sel_y, sel_z);
        o_mem_wdata       = i_in.sample;
        o_res.valid       = 1'b0;
        o_res.bound       = r_best;
        o_res.range_error = r_err;
        i_in.ready        = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // nothing is taken while reset is held
                i_in.ready = i_rst_n;
                o_mem_addr = cell_addr(in_x, in_y, in_z);
                if (i_in.valid && i_rst_n) begin
                    if (t_opcode'(i_in.opcode) == OP_WRITE) begin
                        o_mem.we = in_inside;
                    end else if (!in_inside) begin
                        n_best  = '0;
                        n_err   = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        // corner 0 is read straight off the command
                        o_mem.re = 1'b1;
                        n_cnt    = 4'd1;
                        n_best   = '0;
                        n_err    = 1'b0;
                        n_state  = S_READ;
                    end
                end
            end
            S_READ: begin
                n_best = (mag_now > r_best) ? mag_now : r_best;
                if (r_cnt != CUBE_READS) begin
                    o_mem.re = 1'b1;
                    n_cnt    = r_cnt + 4'd1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_res.valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= o_mem.re;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_best <= n_best;
        r_err  <= n_err;
        if (in_acc) begin
            r_x0 <= in_x;
            r_y0 <= in_y;
            r_z0 <= in_z;
            r_x1 <= step_wrap(in_x, edge_n);
            r_y1 <= step_wrap(in_y, edge_n);
            r_z1 <= step_wrap(in_z, edge_n);
        end
    end

    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_mem.we && o_mem.re))
        else $error("grid write and read in the same cycle");

    a_read_data_lines_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ |-> r_rd_vld)
        else $error("accumulating without read data");

    a_all_corners: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ && n_state == S_DONE |-> r_cnt == CUBE_READS)
        else $error("query finished before all corners were read");

    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.range_error |-> o_res.bound == '0)
        else $error("range error result with nonzero bound");

endmodule

// ===== hw/rtl/periodic_neighbour_max_bound_core.sv =====
// ----------------------------------------------------------------------------
// periodic_neighbour_max_bound_core
// Periodic grid of Q16.16 samples with a 2x2x2 peak magnitude query.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries command items. opcode OP_WRITE stores sample at (x,y,z) when
//   all coordinates are below the edge length; otherwise it is dropped. No
//   result comes back for a write. opcode OP_QUERY returns one item on o_out:
//   the peak |sample| of the cube (x|x+1, y|y+1, z|z+1), with each +1 wrapping
//   to 0 at the last grid index. A query outside the grid returns
//   range_error = 1 and bound = 0 without touching the store.
//   i_cfg_we/i_cfg_wdata set the edge length (values above MAX_EDGE clip);
//   write it only while the core is idle.
// Sequence:
//   A write is stored in the cycle it is accepted. A query issues eight reads
//   through the single port of the grid store, one per cycle, folds in the
//   last read data and hands the result to the output register, which drives
//   o_out.valid; the next item is taken once that register accepts the result.
//   An out-of-range query does no reads and frees i_in in the same way.
// Reset / stall:
//   Reset sets the edge length to 16 and empties the output register; grid
//   contents are not cleared and must be written before they are queried.
//   While o_out stalls, the core keeps taking writes and starts the next
//   query, then holds that query's result, taking no further items, until the output register frees.
// ----------------------------------------------------------------------------
module periodic_neighbour_max_bound_core #(
    parameter int MAX_EDGE = pnmb_pkg::MAX_EDGE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pnmb_in_if.sink     i_in,
    pnmb_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata
);
    import pnmb_pkg::*;

    localparam int DEPTH = MAX_EDGE * MAX_EDGE * MAX_EDGE;
    localparam int AW    = $clog2(DEPTH);

    logic [4:0]  r_edge_len;
    logic        r_out_vld;
    logic [30:0] r_out_bound;
    logic        r_out_err;

    t_mem_ctl    mem_ctl;
    logic [AW-1:0] mem_addr;
    logic [31:0] mem_wdata;
    logic [31:0] mem_rdata;
    t_result     res;
    logic        res_ready;

    // edge length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_len <= EDGE_RESET;
        end else if (i_cfg_we) begin
            r_edge_len <= i_cfg_wdata;
        end
    end

    pnmb_seq #(
        .MAX_EDGE (MAX_EDGE),
        .DEPTH    (DEPTH),
        .AW       (AW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_edge_len  (r_edge_len),
        .o_mem       (mem_ctl),
        .o_mem_addr  (mem_addr),
        .o_mem_wdata (mem_wdata),
        .i_mem_rdata (mem_rdata),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    pnmb_grid #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_grid (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // output register: takes a result when empty or being drained this cycle
    assign res_ready = !r_out_vld || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res.valid && res_ready) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid && res_ready) begin
            r_out_bound <= res.bound;
            r_out_err   <= res.range_error;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.bound       = r_out_bound;
    assign o_out.range_error = r_out_err;

endmodule
